### rtl/core/sssag_pkg.sv
// Package for the slab spread swap address generator.
// Holds field widths, register indexes, reset values and the sequencer state type.
// No dependencies; the core and its checker use it.
package sssag_pkg;

	localparam int MACRO_BITS_DEF = 32;
	localparam int MAX_FANOUT_DEF = 16;

	localparam int MACRO_INDEX_W = 32;
	localparam int MINI_W        = 40;
	localparam int FANOUT_W      = 5;
	localparam int MIX_LEVEL_W   = 6;
	localparam int CFG_DATA_W    = 6;
	localparam int CFG_INDEX_W   = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_FANOUT    = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIX_LEVEL = 1'b1;

	localparam logic [FANOUT_W-1:0]    FANOUT_RST    = 5'd2;
	localparam logic [MIX_LEVEL_W-1:0] MIX_LEVEL_RST = 6'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SLAB,
		ST_DIV,
		ST_MULM,
		ST_MULS,
		ST_PREP,
		ST_EMIT
	} state_t;

endpackage

### rtl/core/slab_spread_swap_address_gen.sv
// Sequence: an accepted macro first has its slab size computed (only on the first macro after
// reset or after a register write), then a bit-serial division of the macro index and the
// setup states MULM, MULS and PREP before the first swap pair.
// Throughput: one pair per cycle while out_ready is high; one macro at a time, in_ready is
// high only while idle. A macro with no pair, or with fanout below two, emits nothing.
// Reset: arst_n clears the sequencer and sets fanout 2, mix_level 1; the slab is recomputed.
module slab_spread_swap_address_gen #(
	parameter int MACRO_BITS = sssag_pkg::MACRO_BITS_DEF,
	parameter int MAX_FANOUT = sssag_pkg::MAX_FANOUT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [sssag_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [sssag_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [sssag_pkg::MACRO_INDEX_W-1:0] macro_index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sssag_pkg::MINI_W-1:0]        from_mini,
	output logic [sssag_pkg::MINI_W-1:0]        to_mini,
	output logic                                last
);

	localparam int FW  = $clog2(MAX_FANOUT + 1);
	localparam int PW  = $clog2(MAX_FANOUT);
	localparam int SW  = MACRO_BITS + 1;
	localparam int PRW = SW + FW;
	localparam int CW  = (FW > sssag_pkg::FANOUT_W) ? FW : sssag_pkg::FANOUT_W;
	localparam int DCW = $clog2(MACRO_BITS);
	localparam int LVW = sssag_pkg::MIX_LEVEL_W;
	localparam int MW  = sssag_pkg::MINI_W;
	localparam int IW  = sssag_pkg::MACRO_INDEX_W;
	localparam logic [PRW-1:0] SLAB_CAP = PRW'(1) << MACRO_BITS;

	sssag_pkg::state_t state_q, state_c;

	logic [sssag_pkg::FANOUT_W-1:0] fanout_q;
	logic [LVW-1:0]                 mix_level_q;
	logic                           slab_ok_q;

	logic [MACRO_BITS-1:0] held_q;
	logic [SW-1:0]         slab_q;
	logic [LVW-1:0]        lvl_cnt_q;
	logic [SW-1:0]         rem_q;
	logic [FW-1:0]         mod_q;
	logic [DCW-1:0]        div_cnt_q;
	logic [PW-1:0]         pos_q;
	logic [PW-1:0]         m_q;
	logic [MW-1:0]         mf_q;
	logic [MW-1:0]         step_q;
	logic [MW-1:0]         from_q;
	logic [MW-1:0]         to_q;

	logic [CW-1:0]         fan_raw_c;
	logic [CW-1:0]         fan_eff_c;
	logic [FW-1:0]         fan_c;
	logic [FW-1:0]         fan_m1_c;
	logic                  fan_small_c;
	logic [MACRO_BITS+IW-1:0] macro_ext_c;
	logic [SW-1:0]         mul_a_c;
	logic [PRW-1:0]        mul_p_c;
	logic [SW-1:0]         slab_sat_c;
	logic [PRW+MW-1:0]     prod_ext_c;
	logic [MW-1:0]         prod_mini_c;
	logic [SW:0]           trial_c;
	logic                  q_bit_c;
	logic [SW:0]           rem_sub_c;
	logic [SW-1:0]         rem_next_c;
	logic [FW:0]           mod_trial_c;
	logic [FW-1:0]         mod_next_c;
	logic                  last_c;
	logic                  out_take_c;

	// fanout above the supported maximum is clamped
	assign fan_raw_c   = CW'(fanout_q);
	assign fan_eff_c   = (fan_raw_c > CW'(MAX_FANOUT)) ? CW'(MAX_FANOUT) : fan_raw_c;
	assign fan_c       = fan_eff_c[FW-1:0];
	assign fan_m1_c    = fan_c - FW'(1);
	assign fan_small_c = (fan_c < FW'(2));

	assign macro_ext_c = (MACRO_BITS + IW)'(macro_index);

	// shared multiplier: every use takes the fanout as its second operand
	assign mul_p_c     = PRW'(mul_a_c) * PRW'(fan_c);
	assign slab_sat_c  = (mul_p_c > SLAB_CAP) ? SLAB_CAP[SW-1:0] : mul_p_c[SW-1:0];
	assign prod_ext_c  = (PRW + MW)'(mul_p_c);
	assign prod_mini_c = prod_ext_c[MW-1:0];

	// restoring division by the slab size; the quotient bits fold into a running mod fanout
	assign trial_c     = {rem_q, held_q[div_cnt_q]};
	assign q_bit_c     = (trial_c >= (SW + 1)'(slab_q));
	assign rem_sub_c   = q_bit_c ? (trial_c - (SW + 1)'(slab_q)) : trial_c;
	assign rem_next_c  = rem_sub_c[SW-1:0];
	assign mod_trial_c = {mod_q, q_bit_c};
	assign mod_next_c  = (mod_trial_c >= (FW + 1)'(fan_c)) ?
		FW'(mod_trial_c - (FW + 1)'(fan_c)) : mod_trial_c[FW-1:0];

	assign last_c      = (FW'(m_q) == fan_m1_c);
	assign out_take_c  = out_valid && out_ready;

	always_comb begin
		state_c = state_q;
		case (state_q)
			sssag_pkg::ST_IDLE: begin
				if (in_valid && !fan_small_c) begin
					state_c = slab_ok_q ? sssag_pkg::ST_DIV : sssag_pkg::ST_SLAB;
				end
			end
			sssag_pkg::ST_SLAB: begin
				if (lvl_cnt_q == '0) begin
					state_c = sssag_pkg::ST_DIV;
				end
			end
			sssag_pkg::ST_DIV: begin
				if (div_cnt_q == '0) begin
					// the last position has no later mini block to swap with
					state_c = (mod_next_c == fan_m1_c) ? sssag_pkg::ST_IDLE : sssag_pkg::ST_MULM;
				end
			end
			sssag_pkg::ST_MULM: state_c = sssag_pkg::ST_MULS;
			sssag_pkg::ST_MULS: state_c = sssag_pkg::ST_PREP;
			sssag_pkg::ST_PREP: state_c = sssag_pkg::ST_EMIT;
			sssag_pkg::ST_EMIT: begin
				if (out_ready && last_c) begin
					state_c = sssag_pkg::ST_IDLE;
				end
			end
			default: state_c = sssag_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		mul_a_c   = slab_q;
		case (state_q)
			sssag_pkg::ST_IDLE: in_ready  = 1'b1;
			sssag_pkg::ST_MULM: mul_a_c   = SW'(held_q);
			sssag_pkg::ST_EMIT: out_valid = 1'b1;
			default: mul_a_c = slab_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sssag_pkg::ST_IDLE;
			fanout_q    <= sssag_pkg::FANOUT_RST;
			mix_level_q <= sssag_pkg::MIX_LEVEL_RST;
			slab_ok_q   <= 1'b0;
		end else begin
			state_q <= state_c;
			if (state_q == sssag_pkg::ST_SLAB && lvl_cnt_q == '0) begin
				slab_ok_q <= 1'b1;
			end
			if (cfg_wr_en) begin
				// any register write invalidates the cached slab size
				slab_ok_q <= 1'b0;
				case (cfg_index)
					sssag_pkg::REG_FANOUT:    fanout_q    <= cfg_data[sssag_pkg::FANOUT_W-1:0];
					sssag_pkg::REG_MIX_LEVEL: mix_level_q <= cfg_data[LVW-1:0];
					default: fanout_q <= fanout_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sssag_pkg::ST_IDLE: begin
				if (in_valid) begin
					held_q    <= macro_ext_c[MACRO_BITS-1:0];
					rem_q     <= '0;
					mod_q     <= '0;
					div_cnt_q <= DCW'(MACRO_BITS - 1);
					if (!slab_ok_q) begin
						slab_q    <= SW'(1);
						lvl_cnt_q <= (mix_level_q == '0) ? '0 : mix_level_q - LVW'(1);
					end
				end
			end
			sssag_pkg::ST_SLAB: begin
				if (lvl_cnt_q != '0) begin
					slab_q    <= slab_sat_c;
					lvl_cnt_q <= lvl_cnt_q - LVW'(1);
				end
			end
			sssag_pkg::ST_DIV: begin
				rem_q     <= rem_next_c;
				mod_q     <= mod_next_c;
				pos_q     <= mod_next_c[PW-1:0];
				div_cnt_q <= div_cnt_q - DCW'(1);
			end
			sssag_pkg::ST_MULM: begin
				mf_q <= prod_mini_c;
			end
			sssag_pkg::ST_MULS: begin
				step_q <= prod_mini_c;
				from_q <= mf_q + MW'(pos_q) + MW'(1);
				to_q   <= mf_q + MW'(pos_q);
				m_q    <= pos_q + PW'(1);
			end
			sssag_pkg::ST_PREP: begin
				to_q <= to_q + step_q;
			end
			sssag_pkg::ST_EMIT: begin
				// advance to the next mini position once the beat is taken
				if (out_take_c && !last_c) begin
					from_q <= from_q + MW'(1);
					to_q   <= to_q + step_q;
					m_q    <= m_q + PW'(1);
				end
			end
			default: held_q <= held_q;
		endcase
	end

	assign from_mini = from_q;
	assign to_mini   = to_q;
	assign last      = last_c;

endmodule

### rtl/core/sssag_checker.sv
// Port-level checker for the slab spread swap address generator, bound to the top level.
// Depends on sssag_pkg for field widths.
module sssag_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [sssag_pkg::MINI_W-1:0] from_mini,
	input logic [sssag_pkg::MINI_W-1:0] to_mini,
	input logic                         last
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(from_mini) && $stable(to_mini)
			&& $stable(last))
	else $error("stalled result beat changed");

	// one macro at a time: no input is taken while pairs are pending
	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
	else $error("input ready while a result beat is pending");

	// the final pair frees the block for the next macro
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> in_ready && !out_valid)
	else $error("block not ready after final pair");

	// pairs of one macro follow back to back with consecutive source indexes
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid
			&& (from_mini == $past(from_mini) + sssag_pkg::MINI_W'(1)))
	else $error("next pair missing or source index not consecutive");

endmodule

bind slab_spread_swap_address_gen sssag_checker u_sssag_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.from_mini (from_mini),
	.to_mini   (to_mini),
	.last      (last)
);

### test/tb_top.sv
// Testbench for slab_spread_swap_address_gen: directed corner cases, then random macro beats.
// Predicts every swap pair from its own copy of fanout, mix level and slab size.
// Depends on sssag_pkg and the generator RTL only.
`timescale 1ns / 1ps

module tb_top;

	localparam int          LIMIT        = 1_000_000;
	localparam int          SETTLE_WAIT  = 160;
	localparam int          REPORT_CAP   = 40;
	localparam logic [63:0] SLAB_CAP     = 64'h1_0000_0000;
	localparam logic [63:0] FANOUT_CLAMP = 64'(sssag_pkg::MAX_FANOUT_DEF);

	typedef struct packed {
		logic [sssag_pkg::MINI_W-1:0] from_idx;
		logic [sssag_pkg::MINI_W-1:0] to_idx;
		logic                         last_flag;
	} swap_pair_t;

	class spread_scoreboard;
		logic [sssag_pkg::FANOUT_W-1:0]    fanout_reg;
		logic [sssag_pkg::MIX_LEVEL_W-1:0] level_reg;
		logic [63:0]                       slab;
		swap_pair_t                        pairs[$];
		int                                errors;
		int                                macros;
		int                                silent;
		int                                checked;

		function new();
			fanout_reg = sssag_pkg::FANOUT_RST;
			level_reg  = sssag_pkg::MIX_LEVEL_RST;
			errors     = 0;
			macros     = 0;
			silent     = 0;
			checked    = 0;
			update_slab();
		endfunction

		function logic [63:0] eff_fanout();
			logic [63:0] f;
			f = {59'd0, fanout_reg};
			if (f > FANOUT_CLAMP) f = FANOUT_CLAMP;
			return f;
		endfunction

		// slab = fanout^(level-1), capped at one past the largest macro index
		function void update_slab();
			logic [63:0] f;
			logic [63:0] s;
			int          k;
			f = eff_fanout();
			s = 64'd1;
			for (k = 1; k < int'(level_reg); k++) begin
				if (f != 0 && s > SLAB_CAP / f) begin
					s = SLAB_CAP;
					break;
				end
				s = s * f;
				if (s > SLAB_CAP) begin
					s = SLAB_CAP;
					break;
				end
			end
			if (s == 0) s = 64'd1;
			slab = s;
		endfunction

		function void set_register(logic [sssag_pkg::CFG_INDEX_W-1:0] idx,
			logic [sssag_pkg::CFG_DATA_W-1:0] data);
			if (idx == sssag_pkg::REG_FANOUT)
				fanout_reg = data[sssag_pkg::FANOUT_W-1:0];
			else if (idx == sssag_pkg::REG_MIX_LEVEL)
				level_reg = data[sssag_pkg::MIX_LEVEL_W-1:0];
			update_slab();
		endfunction

		function void note_macro(logic [sssag_pkg::MACRO_INDEX_W-1:0] m);
			logic [63:0] f;
			logic [63:0] mac;
			logic [63:0] pos;
			logic [63:0] mini;
			logic [63:0] tmp;
			swap_pair_t  e;
			macros++;
			f   = eff_fanout();
			mac = {32'd0, m};
			if (f < 2) begin
				silent++;
				return;
			end
			pos = (mac / slab) % f;
			if (pos == f - 1) silent++;
			for (mini = pos + 1; mini < f; mini++) begin
				tmp         = mac * f + mini;
				e.from_idx  = tmp[sssag_pkg::MINI_W-1:0];
				tmp         = (mac + slab * (mini - pos)) * f + pos;
				e.to_idx    = tmp[sssag_pkg::MINI_W-1:0];
				e.last_flag = (mini + 1 == f);
				pairs.push_back(e);
			end
		endfunction

		function void complain(string what, logic [sssag_pkg::MINI_W-1:0] want,
			logic [sssag_pkg::MINI_W-1:0] got);
			errors++;
			if (errors <= REPORT_CAP)
				$display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
		endfunction

		function void check_pair(logic [sssag_pkg::MINI_W-1:0] fr,
			logic [sssag_pkg::MINI_W-1:0] to, logic lst);
			swap_pair_t e;
			if (pairs.size() == 0) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t: unexpected swap pair, expected none actual from %h to %h last %b",
						$time, fr, to, lst);
				return;
			end
			e = pairs.pop_front();
			checked++;
			if (fr !== e.from_idx) complain("from_mini", e.from_idx, fr);
			if (to !== e.to_idx) complain("to_mini", e.to_idx, to);
			if (lst !== e.last_flag) complain("last", {39'd0, e.last_flag}, {39'd0, lst});
		endfunction
	endclass

	logic                                clk         = 1'b0;
	logic                                arst_n      = 1'b0;
	logic                                cfg_wr_en   = 1'b0;
	logic [sssag_pkg::CFG_INDEX_W-1:0]   cfg_index   = sssag_pkg::REG_FANOUT;
	logic [sssag_pkg::CFG_DATA_W-1:0]    cfg_data    = '0;
	logic                                in_valid    = 1'b0;
	logic                                in_ready;
	logic [sssag_pkg::MACRO_INDEX_W-1:0] macro_index = '0;
	logic                                out_valid;
	logic                                out_ready   = 1'b0;
	logic [sssag_pkg::MINI_W-1:0]        from_mini;
	logic [sssag_pkg::MINI_W-1:0]        to_mini;
	logic                                last;

	spread_scoreboard book = new();

	int cycle_count = 0;
	int stall_left  = 0;
	int sink_roll;
	bit sink_eager  = 1'b0;
	bit send_burst  = 1'b0;
	int settings    = 1;

	slab_spread_swap_address_gen dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.macro_index(macro_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.from_mini  (from_mini),
		.to_mini    (to_mini),
		.last       (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// check the beat taken at this edge, then pick ready for the next cycle
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.check_pair(from_mini, to_mini, last);
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (sink_eager) begin
			out_ready <= 1'b1;
		end else begin
			sink_roll = $urandom_range(0, 31);
			if (sink_roll < 20) begin
				out_ready <= 1'b1;
			end else if (sink_roll < 30) begin
				stall_left = $urandom_range(0, 3);
				out_ready <= 1'b0;
			end else begin
				stall_left = $urandom_range(10, 40);
				out_ready <= 1'b0;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (send_burst) return 0;
		if (r < 14) return $urandom_range(0, 2);
		if (r < 19) return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [sssag_pkg::MACRO_INDEX_W-1:0] pick_macro();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return $urandom;
		if (r < 8) return $urandom_range(0, 255);
		return 32'hFFFF_FFFF - $urandom_range(0, 255);
	endfunction

	task automatic send_macro(input logic [sssag_pkg::MACRO_INDEX_W-1:0] v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		macro_index <= v;
		do @(posedge clk); while (!in_ready);
		book.note_macro(v);
	endtask

	// drop valid and wait out every pair plus any silent macro still in flight
	task automatic settle();
		in_valid <= 1'b0;
		while (book.pairs.size() != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sssag_pkg::CFG_INDEX_W-1:0] idx,
		input logic [sssag_pkg::CFG_DATA_W-1:0] d);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		book.set_register(idx, d);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [sssag_pkg::CFG_DATA_W-1:0] fd,
		input logic [sssag_pkg::CFG_DATA_W-1:0] ld);
		settle();
		write_reg(sssag_pkg::REG_FANOUT, fd);
		write_reg(sssag_pkg::REG_MIX_LEVEL, ld);
		settings++;
	endtask

	initial begin
		logic [sssag_pkg::CFG_DATA_W-1:0] fd;
		logic [sssag_pkg::CFG_DATA_W-1:0] ld;
		int                               ph;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: fanout 2, slab 1
		send_macro(32'h0000_0000);
		send_macro(32'h0000_0001);
		send_macro(32'hFFFF_FFFF);
		send_macro(32'hFFFF_FFFE);

		// widest fanout, full runs of 15 pairs and empty ones
		configure(6'd16, 6'd1);
		send_macro(32'h0000_0000);
		send_macro(32'h0000_000F);
		send_macro(32'hFFFF_FFFF);
		send_macro(32'hFFFF_FFF0);

		// slab exactly one past the index range
		configure(6'd16, 6'd9);
		send_macro(32'hFFFF_FFFF);
		send_macro(32'h0000_0000);

		// slab saturates
		configure(6'd16, 6'h3F);
		send_macro(32'h8000_0000);

		// level zero behaves as level one
		configure(6'd3, 6'd0);
		send_macro(32'h0000_0005);
		send_macro(32'h0000_0007);

		// fanout data with the top bit set is masked; slab saturates from above
		configure(6'h23, 6'd33);
		send_macro(32'hDEAD_BEEF);

		// fanout above the maximum is clamped
		configure(6'd31, 6'd2);
		send_macro(32'h1234_5678);

		// fanout below two gives nothing
		configure(6'd1, 6'd5);
		send_macro(32'hA5A5_A5A5);
		configure(6'd0, 6'h3F);
		send_macro(32'h5A5A_5A5A);

		configure(6'd2, 6'd32);
		send_macro(32'h7FFF_FFFF);
		send_macro(32'h8000_0000);
		send_macro(32'hFFFF_FFFF);

		for (ph = 0; ph < 8; ph++) begin
			fd = 6'($urandom_range(2, 16));
			if ($urandom_range(0, 5) == 0) fd = 6'($urandom_range(17, 31));
			fd[5] = 1'($urandom_range(0, 1));
			ld = 6'($urandom_range(1, 6));
			if ($urandom_range(0, 4) == 0) ld = 6'($urandom_range(0, 40));
			if ($urandom_range(0, 7) == 0) ld = 6'($urandom_range(41, 63));
			send_burst = (ph % 3 == 0);
			sink_eager = (ph % 4 == 1);
			configure(fd, ld);
			repeat (16) begin
				if ($urandom_range(0, 24) == 0) begin
					in_valid <= 1'b0;
					do @(posedge clk); while (book.pairs.size() != 0);
				end
				send_macro(pick_macro());
			end
		end

		settle();
		$display("tb_top: %0d macro beats over %0d register settings, %0d swap pairs checked",
			book.macros, settings, book.checked);
		$display("tb_top: %0d macros produced no pair", book.silent);
		if (book.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
